// ===== src/mbpc_pkg.sv =====
// ----------------------------------------------------------------------------
// mbpc_pkg
// Shared types, codes and constants of the media button press classifier.
// ----------------------------------------------------------------------------
package mbpc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;
    localparam int NUM_BTN         = 5;

    // Button lanes, in order
    localparam int KEY_UP     = 0;
    localparam int KEY_DOWN   = 1;
    localparam int KEY_RIGHT  = 2;
    localparam int KEY_LEFT   = 3;
    localparam int KEY_SELECT = 4;

    // Input actions
    localparam logic [1:0] ACT_STATUS  = 2'd0;
    localparam logic [1:0] ACT_TICK    = 2'd1;
    localparam logic [1:0] ACT_CONSUME = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_ENABLE  = 2'd0;
    localparam logic [1:0] REG_SHORT   = 2'd1;
    localparam logic [1:0] REG_LONG    = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // Modes
    localparam logic [2:0] MODE_OTHER     = 3'd0;
    localparam logic [2:0] MODE_PLAYING   = 3'd1;
    localparam logic [2:0] MODE_PAUSED    = 3'd2;
    localparam logic [2:0] MODE_RING      = 3'd3;
    localparam logic [2:0] MODE_CALL_END  = 3'd4;
    localparam logic [2:0] MODE_RESERVED  = 3'd6;

    // Commands
    localparam logic [1:0] VOL_NONE     = 2'd0;
    localparam logic [1:0] VOL_UP       = 2'd1;
    localparam logic [1:0] VOL_DOWN     = 2'd2;
    localparam logic [2:0] MUS_NONE     = 3'd0;
    localparam logic [2:0] MUS_NEXT     = 3'd1;
    localparam logic [2:0] MUS_PREV     = 3'd2;
    localparam logic [2:0] MUS_PLAY     = 3'd3;
    localparam logic [2:0] MUS_PAUSE    = 3'd4;
    localparam logic [1:0] CALL_NONE    = 2'd0;
    localparam logic [1:0] CALL_ANSWER  = 2'd1;
    localparam logic [1:0] CALL_DECLINE = 2'd2;

    // Reset values of the configuration registers
    localparam logic [7:0]  SHORT_RESET   = 8'd10;
    localparam logic [15:0] LONG_RESET    = 16'd100;
    localparam logic [7:0]  TIMEOUT_RESET = 8'd5;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_SHORT = 2'd1,
        CLS_HIT   = 2'd2,
        CLS_LONG  = 2'd3
    } press_class_t;

    typedef enum logic [1:0] {
        LVL_REL     = 2'd0,
        LVL_PRESS   = 2'd1,
        LVL_UNKNOWN = 2'd2
    } level_t;

    // Per-lane control from the top level
    typedef struct packed {
        logic clear_all;
        logic load_level;
        logic level_bit;
        logic advance;
        logic clear_press;
        logic consume;
    } lane_ctrl_t;

    // Per-lane report after the tick advance
    typedef struct packed {
        logic         pressed;
        press_class_t cls;
    } lane_stat_t;

    // Merged result of one tick
    typedef struct packed {
        logic [1:0]         vol;
        logic [2:0]         music;
        logic [1:0]         call;
        logic [NUM_BTN-1:0] consume;
        logic               multi_press;
    } merge_out_t;

endpackage

// ===== src/mbpc_lane.sv =====
// ----------------------------------------------------------------------------
// mbpc_lane
// One button: level, press counter and press class, advanced once per tick.
// ----------------------------------------------------------------------------
module mbpc_lane
    import mbpc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lane_ctrl_t  ctrl,
    input  logic [7:0]  short_count,
    input  logic [15:0] long_count,
    output lane_stat_t  stat
);

    localparam logic [COUNT_WIDTH-1:0] SAT = {{(COUNT_WIDTH-1){1'b1}}, 1'b0};

    logic [COUNT_WIDTH-1:0] count_reg, count_next, adv_count, count_inc;
    press_class_t           class_reg, class_next, adv_class;
    level_t                 level_reg, level_next;
    logic                   pressed;

    always_comb
    begin
        count_inc = count_reg + COUNT_WIDTH'(1);
        adv_count = count_reg;
        adv_class = class_reg;
        pressed   = 1'b0;
        unique case (level_reg)
            LVL_PRESS:
            begin
                pressed = 1'b1;
                if (count_inc >= SAT)
                begin
                    adv_count = SAT;
                    adv_class = CLS_NONE;
                end
                else
                begin
                    adv_count = count_inc;
                    if (count_inc == COUNT_WIDTH'(short_count))
                        adv_class = CLS_SHORT;
                    else if (16'(count_inc) == long_count)
                        adv_class = CLS_LONG;
                end
            end
            LVL_REL:
            begin
                adv_count = '0;
                adv_class = (class_reg == CLS_SHORT) ? CLS_HIT : CLS_NONE;
            end
            default:
            begin
                adv_count = SAT;
                adv_class = CLS_NONE;
            end
        endcase
    end

    assign stat.pressed = pressed;
    assign stat.cls     = adv_class;

    always_comb
    begin
        count_next = count_reg;
        class_next = class_reg;
        level_next = level_reg;
        priority if (ctrl.clear_all)
        begin
            count_next = SAT;
            class_next = CLS_NONE;
            level_next = LVL_UNKNOWN;
        end
        else if (ctrl.load_level)
        begin
            level_next = ctrl.level_bit ? LVL_PRESS : LVL_REL;
        end
        else if (ctrl.advance)
        begin
            if (ctrl.clear_press)
            begin
                count_next = SAT;
                class_next = CLS_NONE;
            end
            else
            begin
                count_next = adv_count;
                class_next = ctrl.consume ? CLS_NONE : adv_class;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= SAT;
            class_reg <= CLS_NONE;
            level_reg <= LVL_UNKNOWN;
        end
        else
        begin
            count_reg <= count_next;
            class_reg <= class_next;
            level_reg <= level_next;
        end
    end

endmodule

// ===== src/mbpc_merge.sv =====
// ----------------------------------------------------------------------------
// mbpc_merge
// Combines the lane classes into at most one command per tick by mode.
// ----------------------------------------------------------------------------
module mbpc_merge
    import mbpc_pkg::*;
(
    input  logic [2:0]           mode_seen,
    input  lane_stat_t [NUM_BTN-1:0] stat,
    output merge_out_t           result
);

    logic [NUM_BTN-1:0] hit, lng;
    logic [6:0]         ev;
    logic [2:0]         ev_cnt;
    logic [2:0]         press_cnt;

    always_comb
    begin
        for (int i = 0; i < NUM_BTN; i++)
        begin
            hit[i] = (stat[i].cls == CLS_HIT);
            lng[i] = (stat[i].cls == CLS_LONG);
        end

        press_cnt = '0;
        for (int i = 0; i < NUM_BTN; i++)
            press_cnt = press_cnt + 3'(stat[i].pressed);

        ev = {hit[KEY_RIGHT], hit[KEY_LEFT], hit[KEY_SELECT],
              lng[KEY_DOWN], hit[KEY_DOWN], lng[KEY_UP], hit[KEY_UP]};
        ev_cnt = '0;
        for (int i = 0; i < 7; i++)
            ev_cnt = ev_cnt + 3'(ev[i]);

        result.vol         = VOL_NONE;
        result.music       = MUS_NONE;
        result.call        = CALL_NONE;
        result.consume     = '0;
        result.multi_press = (press_cnt > 3'd1);

        unique case (mode_seen)
            MODE_PLAYING, MODE_PAUSED:
            begin
                result.consume = hit | lng;
                // drop all commands when more than one command arises
                if (ev_cnt == 3'd1)
                begin
                    if (hit[KEY_UP])
                        result.vol = VOL_UP;
                    else if (hit[KEY_DOWN])
                        result.vol = VOL_DOWN;

                    if (lng[KEY_UP] || hit[KEY_RIGHT])
                        result.music = MUS_NEXT;
                    else if (lng[KEY_DOWN] || hit[KEY_LEFT])
                        result.music = MUS_PREV;
                    else if (hit[KEY_SELECT])
                        result.music = (mode_seen == MODE_PLAYING) ? MUS_PAUSE : MUS_PLAY;
                end
            end
            MODE_RING:
            begin
                result.consume[KEY_UP]   = hit[KEY_UP] | lng[KEY_UP];
                result.consume[KEY_DOWN] = hit[KEY_DOWN] | lng[KEY_DOWN];
                if (hit[KEY_UP] != hit[KEY_DOWN])
                    result.call = hit[KEY_UP] ? CALL_ANSWER : CALL_DECLINE;
            end
            MODE_CALL_END:
            begin
                result.consume[KEY_DOWN] = hit[KEY_DOWN] | lng[KEY_DOWN];
                if (hit[KEY_DOWN])
                    result.call = CALL_DECLINE;
            end
            default:
            begin
                result.consume = '0;
            end
        endcase
    end

endmodule

// ===== src/media_button_press_classifier_unit.sv =====
// ----------------------------------------------------------------------------
// media_button_press_classifier_unit
// Five-button short/long press classifier that latches media commands.
// ----------------------------------------------------------------------------
// Every transaction (status, tick or consume) gives exactly one result
// transaction, taken into the output register on the edge that accepts it, so
// one transaction per clock is sustained while the output side keeps tready
// high. Five button lanes advance in parallel on a tick and a merge stage maps
// their hits and long holds to commands. Results show the latched commands and
// the link state after the transaction. The user must make configuration
// writes only while no transaction is outstanding; the block does not enforce
// this. Writing block_enabled from 0 to 1 clears all press state.
module media_button_press_classifier_unit
    import mbpc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] action, [9:2] button_byte, [17:10] status_byte,
    // [20:18] consume_mask, [23:21] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] volume_command, [4:2] music_command, [6:5] call_command,
    // [7] link_alive
    output logic [7:0]  m_axis_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic [1:0] action;
    logic [7:0] button_byte, status_byte;
    logic [2:0] consume_mask;

    assign action       = s_axis_tdata[1:0];
    assign button_byte  = s_axis_tdata[9:2];
    assign status_byte  = s_axis_tdata[17:10];
    assign consume_mask = s_axis_tdata[20:18];

    logic        enable_reg;
    logic [7:0]  short_reg;
    logic [15:0] long_reg;
    logic [7:0]  timeout_reg;

    logic [2:0]  mode_now_reg, mode_now_next;
    logic [2:0]  mode_seen_reg, mode_seen_next;
    logic [7:0]  silence_reg, silence_next;
    logic [1:0]  held_vol_reg, held_vol_next;
    logic [2:0]  held_mus_reg, held_mus_next;
    logic [1:0]  held_call_reg, held_call_next;

    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;

    logic        fire, tick_run, tick_zero, cfg_open, clear_all, clear_press;
    logic        status_load, consume_act;
    logic [3:0]  mode_raw;

    lane_ctrl_t [NUM_BTN-1:0] lane_ctrl;
    lane_stat_t [NUM_BTN-1:0] lane_stat;
    merge_out_t               merged;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign fire          = s_axis_tvalid && s_axis_tready;

    assign tick_run    = fire && (action == ACT_TICK) && enable_reg && (silence_reg != 8'd0);
    assign tick_zero   = fire && (action == ACT_TICK) && enable_reg && (silence_reg == 8'd0);
    assign cfg_open    = cfg_we && (cfg_index == REG_ENABLE) && cfg_wdata[0] && !enable_reg;
    assign clear_all   = tick_zero || cfg_open;
    assign status_load = fire && (action == ACT_STATUS);
    assign consume_act = fire && (action == ACT_CONSUME);
    assign clear_press = (mode_seen_reg != mode_now_reg) || merged.multi_press;
    assign mode_raw    = status_byte[7:4];

    genvar g;
    generate
        for (g = 0; g < NUM_BTN; g++)
        begin : g_lane
            assign lane_ctrl[g].clear_all   = clear_all;
            assign lane_ctrl[g].load_level  = status_load;
            assign lane_ctrl[g].level_bit   = button_byte[7-g];
            assign lane_ctrl[g].advance     = tick_run;
            assign lane_ctrl[g].clear_press = clear_press;
            assign lane_ctrl[g].consume     = merged.consume[g];

            mbpc_lane #(
                .COUNT_WIDTH (COUNT_WIDTH)
            ) u_lane (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (lane_ctrl[g]),
                .short_count (short_reg),
                .long_count  (long_reg),
                .stat        (lane_stat[g])
            );
        end
    endgenerate

    mbpc_merge u_merge (
        .mode_seen (mode_seen_reg),
        .stat      (lane_stat),
        .result    (merged)
    );

    always_comb
    begin
        silence_next   = silence_reg;
        mode_now_next  = mode_now_reg;
        mode_seen_next = mode_seen_reg;
        held_vol_next  = held_vol_reg;
        held_mus_next  = held_mus_reg;
        held_call_next = held_call_reg;

        priority if (clear_all)
        begin
            silence_next   = '0;
            mode_now_next  = MODE_OTHER;
            mode_seen_next = MODE_OTHER;
            held_vol_next  = VOL_NONE;
            held_mus_next  = MUS_NONE;
            held_call_next = CALL_NONE;
        end
        else if (status_load)
        begin
            silence_next  = timeout_reg;
            mode_now_next = (mode_raw >= 4'd6) ? MODE_RESERVED : mode_raw[2:0];
        end
        else if (tick_run)
        begin
            silence_next = silence_reg - 8'd1;
            if (clear_press)
            begin
                mode_seen_next = mode_now_reg;
                held_vol_next  = VOL_NONE;
                held_mus_next  = MUS_NONE;
                held_call_next = CALL_NONE;
            end
            else
            begin
                // latch a new command only into an empty slot
                if (held_vol_reg == VOL_NONE)
                    held_vol_next = merged.vol;
                if (held_mus_reg == MUS_NONE)
                    held_mus_next = merged.music;
                if (held_call_reg == CALL_NONE)
                    held_call_next = merged.call;
            end
        end
        else if (consume_act)
        begin
            if (consume_mask[0])
                held_vol_next = VOL_NONE;
            if (consume_mask[1])
                held_mus_next = MUS_NONE;
            if (consume_mask[2])
                held_call_next = CALL_NONE;
        end
    end

    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (fire)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {(silence_next != 8'd0), held_call_next, held_mus_next,
                            held_vol_next};
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            short_reg   <= SHORT_RESET;
            long_reg    <= LONG_RESET;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE:  enable_reg  <= cfg_wdata[0];
                REG_SHORT:   short_reg   <= cfg_wdata[7:0];
                REG_LONG:    long_reg    <= cfg_wdata;
                REG_TIMEOUT: timeout_reg <= cfg_wdata[7:0];
                default:     enable_reg  <= enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_reg   <= '0;
            mode_now_reg  <= MODE_OTHER;
            mode_seen_reg <= MODE_OTHER;
            held_vol_reg  <= VOL_NONE;
            held_mus_reg  <= MUS_NONE;
            held_call_reg <= CALL_NONE;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            silence_reg   <= silence_next;
            mode_now_reg  <= mode_now_next;
            mode_seen_reg <= mode_seen_next;
            held_vol_reg  <= held_vol_next;
            held_mus_reg  <= held_mus_next;
            held_call_reg <= held_call_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    // An empty output register must never stall the input side
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output register");

    // The result of a transaction reports the link state it left behind
    a_alive_matches: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> m_axis_tdata[7] == (silence_reg != 8'd0))
        else $error("link_alive does not match silence timer");

    // A tick on an expired link clears mode and all held commands
    a_expire_clears: assert property (@(posedge clk) disable iff (!rst_n)
        tick_zero |=> (mode_seen_reg == MODE_OTHER) && (held_vol_reg == VOL_NONE)
                      && (held_mus_reg == MUS_NONE) && (held_call_reg == CALL_NONE))
        else $error("expired tick left state behind");

    // Held commands stay within their code sets
    a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
        (held_vol_reg != 2'd3) && (held_call_reg != 2'd3) && (held_mus_reg <= MUS_PAUSE))
        else $error("held command out of range");

endmodule
